[sv/dpe_pkg.sv]
// Package for the data-processing execute block: word and index types,
// opcode and shift-kind codes, the ALU result struct and a rotate helper.
// No dependencies; every other source file but dpe_checker.sv imports it.
package dpe_pkg;

	typedef logic [31:0] word_t;
	typedef logic [3:0]  reg_idx_t;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13
	} opcode_t;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	typedef struct packed {
		word_t value;
		logic  writes;
		logic  known;
	} alu_res_t;

	function automatic word_t ror32(word_t v, logic [4:0] n);
		logic [63:0] d;
		d = {v, v} >> n;
		return d[31:0];
	endfunction

endpackage

[sv/dpe_regfile.sv]
// Register file: two copies of a 16 x 32 synchronous memory with a registered
// read, write-through forwarding at the read edge, reset-cleared valid bits.
// Depends on dpe_pkg.
module dpe_regfile (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  dpe_pkg::reg_idx_t rd_addr_n,
	input  dpe_pkg::reg_idx_t rd_addr_m,
	input  dpe_pkg::reg_idx_t rd_addr_s,
	output dpe_pkg::word_t   rd_data_n,
	output dpe_pkg::word_t   rd_data_m,
	output dpe_pkg::word_t   rd_data_s,
	input  logic             wr_en,
	input  dpe_pkg::reg_idx_t wr_addr,
	input  dpe_pkg::word_t   wr_data
);
	import dpe_pkg::*;

	// copy a serves Rn and Rm, copy b serves Rs
	word_t mem_a [16];
	word_t mem_b [16];
	logic [15:0] valid_q;

	word_t raw_n_q, raw_m_q, raw_s_q;
	word_t fwd_data_q;
	logic  fwd_n_q, fwd_m_q, fwd_s_q;
	logic  ok_n_q, ok_m_q, ok_s_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_addr] <= wr_data;
			mem_b[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_n_q <= mem_a[rd_addr_n];
			raw_m_q <= mem_a[rd_addr_m];
			raw_s_q <= mem_b[rd_addr_s];
		end
	end

	// capture a write landing on the same edge as the read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= wr_data;
			fwd_n_q    <= wr_en && (wr_addr == rd_addr_n);
			fwd_m_q    <= wr_en && (wr_addr == rd_addr_m);
			fwd_s_q    <= wr_en && (wr_addr == rd_addr_s);
			ok_n_q     <= valid_q[rd_addr_n];
			ok_m_q     <= valid_q[rd_addr_m];
			ok_s_q     <= valid_q[rd_addr_s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data_n = fwd_n_q ? fwd_data_q : (ok_n_q ? raw_n_q : '0);
	assign rd_data_m = fwd_m_q ? fwd_data_q : (ok_m_q ? raw_m_q : '0);
	assign rd_data_s = fwd_s_q ? fwd_data_q : (ok_s_q ? raw_s_q : '0);

endmodule

[sv/dpe_operand2.sv]
// Operand2 builder: rotated 8-bit immediate, or Rm through the barrel
// shifter by a constant or by the low byte of Rs. Depends on dpe_pkg.
module dpe_operand2 (
	input  dpe_pkg::word_t instr,
	input  dpe_pkg::word_t rm_val,
	input  dpe_pkg::word_t rs_val,
	output dpe_pkg::word_t op2
);
	import dpe_pkg::*;

	logic [7:0] amt;
	logic       big;
	word_t      shifted;

	assign amt = instr[4] ? rs_val[7:0] : {3'b000, instr[11:7]};
	assign big = |amt[7:5];

	always_comb begin
		case (instr[6:5])
			SH_LSL:  shifted = big ? '0 : (rm_val << amt[4:0]);
			SH_LSR:  shifted = big ? '0 : (rm_val >> amt[4:0]);
			SH_ASR:  shifted = big ? {32{rm_val[31]}}
			                       : word_t'($signed(rm_val) >>> amt[4:0]);
			SH_ROR:  shifted = ror32(rm_val, amt[4:0]);
			default: shifted = rm_val;
		endcase
	end

	assign op2 = instr[25] ? ror32({24'h000000, instr[7:0]}, {instr[11:8], 1'b0})
	                       : shifted;

endmodule

[sv/dpe_alu.sv]
// ALU: carries out the opcode on Rn and operand2, reports whether Rd is
// written and whether the opcode is a listed one. Depends on dpe_pkg.
module dpe_alu (
	input  logic [3:0]        opcode,
	input  dpe_pkg::word_t    rn_val,
	input  dpe_pkg::word_t    op2,
	output dpe_pkg::alu_res_t res
);
	import dpe_pkg::*;

	always_comb begin
		res = '{value: '0, writes: 1'b0, known: 1'b1};
		case (opcode_t'(opcode))
			OP_AND: begin res.value = rn_val & op2; res.writes = 1'b1; end
			OP_EOR: begin res.value = rn_val ^ op2; res.writes = 1'b1; end
			OP_SUB: begin res.value = rn_val - op2; res.writes = 1'b1; end
			OP_RSB: begin res.value = op2 - rn_val; res.writes = 1'b1; end
			OP_ADD: begin res.value = rn_val + op2; res.writes = 1'b1; end
			OP_TST: res.value = rn_val & op2;
			OP_TEQ: res.value = rn_val ^ op2;
			OP_CMP: res.value = rn_val - op2;
			OP_ORR: begin res.value = rn_val | op2; res.writes = 1'b1; end
			OP_MOV: begin res.value = op2; res.writes = 1'b1; end
			// unlisted opcodes change nothing
			default: res.known = 1'b0;
		endcase
	end

endmodule

[sv/data_processing_execute.sv]
// Channel      Handshake                           Payload
// instruction  instruction_valid/instruction_ready instruction[31:0]
// result       result_valid/result_ready           dest_index, alu_value, wrote_dest,
//                                                  flag_negative, flag_zero_out
// One instruction per cycle sustained while the output is not stalled.
// Stage 1 is the register file read cycle; the shifter and ALU run on the read data
// and write Rd back as the instruction moves into the output register.
// A write on the same edge as a read is forwarded inside the register file.
// Reset clears the register file valid bits and the flags at once; no clearing pass.
// A stalled output holds stage 1, and the next transaction is taken as soon as it moves.
// Top level of the data-processing execute block. Depends on dpe_pkg,
// dpe_regfile, dpe_operand2 and dpe_alu.
module data_processing_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        instruction_valid,
	output logic        instruction_ready,
	input  logic [31:0] instruction,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [3:0]  dest_index,
	output logic [31:0] alu_value,
	output logic        wrote_dest,
	output logic        flag_negative,
	output logic        flag_zero_out
);
	import dpe_pkg::*;

	logic     accept_in;
	logic     s1_adv;
	logic     s1_valid_q;
	word_t    instr_s1;
	logic     out_valid_q;
	word_t    rn_val, rm_val, rs_val, op2;
	alu_res_t res;
	logic     neg_q, zero_q;
	logic     neg_next, zero_next;
	reg_idx_t dest_q;
	word_t    value_q;
	logic     wrote_q;

	assign accept_in         = instruction_valid && instruction_ready;
	assign s1_adv            = s1_valid_q && (!out_valid_q || result_ready);
	assign instruction_ready = !s1_valid_q || s1_adv;

	dpe_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept_in),
		.rd_addr_n (instruction[19:16]),
		.rd_addr_m (instruction[3:0]),
		.rd_addr_s (instruction[11:8]),
		.rd_data_n (rn_val),
		.rd_data_m (rm_val),
		.rd_data_s (rs_val),
		.wr_en     (s1_adv && res.writes),
		.wr_addr   (instr_s1[15:12]),
		.wr_data   (res.value)
	);

	dpe_operand2 u_operand2 (
		.instr  (instr_s1),
		.rm_val (rm_val),
		.rs_val (rs_val),
		.op2    (op2)
	);

	dpe_alu u_alu (
		.opcode (instr_s1[24:21]),
		.rn_val (rn_val),
		.op2    (op2),
		.res    (res)
	);

	// flags follow the value only for listed opcodes with S set
	assign neg_next  = (res.known && instr_s1[20]) ? res.value[31] : neg_q;
	assign zero_next = (res.known && instr_s1[20]) ? (res.value == '0) : zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			neg_q       <= 1'b0;
			zero_q      <= 1'b0;
		end else begin
			s1_valid_q  <= accept_in || (s1_valid_q && !s1_adv);
			out_valid_q <= s1_adv || (out_valid_q && !result_ready);
			if (s1_adv) begin
				neg_q  <= neg_next;
				zero_q <= zero_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			instr_s1 <= instruction;
		end
		if (s1_adv) begin
			dest_q  <= instr_s1[15:12];
			value_q <= res.value;
			wrote_q <= res.writes;
		end
	end

	assign result_valid  = out_valid_q;
	assign dest_index    = dest_q;
	assign alu_value     = value_q;
	assign wrote_dest    = wrote_q;
	assign flag_negative = neg_q;
	assign flag_zero_out = zero_q;

endmodule

[sv/dpe_checker.sv]
// Port-level checker for data_processing_execute and the bind that
// attaches it. Depends only on the top level's ports.
module dpe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        instruction_valid,
	input logic        instruction_ready,
	input logic [31:0] instruction,
	input logic        result_valid,
	input logic        result_ready,
	input logic [3:0]  dest_index,
	input logic [31:0] alu_value,
	input logic        wrote_dest,
	input logic        flag_negative,
	input logic        flag_zero_out
);

	// a pending result stays up until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result_valid dropped before the transaction");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(dest_index) && $stable(alu_value)
			&& $stable(wrote_dest) && $stable(flag_negative) && $stable(flag_zero_out))
		else $error("result payload changed while stalled");

	// input only backs up when the output is full and stalled
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!instruction_ready |-> result_valid && !result_ready)
		else $error("instruction_ready low without an output stall");

	// a fresh result must trace back to an accepted transaction
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(instruction_valid && instruction_ready, 2))
		else $error("result appeared without a matching instruction");

endmodule

bind data_processing_execute dpe_checker u_dpe_checker (.*);

[tb/data_processing_execute_tb.sv]
// Testbench for data_processing_execute: directed and random instruction traffic,
// checked against an in-bench model of the register file, shifter, ALU and flags.
// Depends on dpe_pkg and the data_processing_execute RTL.
`timescale 1ns / 1ps

module data_processing_execute_tb;
	import dpe_pkg::*;

	typedef struct {
		reg_idx_t dest;
		word_t    value;
		logic     wrote;
		logic     neg;
		logic     zero;
	} exec_result_t;

	// Opcodes with no defined operation; the block must leave all state alone.
	localparam logic [3:0] UNLISTED_OPS [6] = '{4'd5, 4'd6, 4'd7, 4'd11, 4'd14, 4'd15};
	localparam opcode_t LISTED_OPS [10] = '{OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
		OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        instruction_valid;
	logic        instruction_ready;
	logic [31:0] instruction;
	logic        result_valid;
	logic        result_ready;
	logic [3:0]  dest_index;
	logic [31:0] alu_value;
	logic        wrote_dest;
	logic        flag_negative;
	logic        flag_zero_out;

	// Model state
	word_t model_regs [16];
	logic  model_neg;
	logic  model_zero;

	exec_result_t pending_results [$];

	bit send_gaps;
	bit recv_gaps;
	int hold_cycles;
	int sent_count;
	int checked_count;
	int written_count;
	int mismatch_count;

	data_processing_execute dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.instruction_valid (instruction_valid),
		.instruction_ready (instruction_ready),
		.instruction       (instruction),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.dest_index        (dest_index),
		.alu_value         (alu_value),
		.wrote_dest        (wrote_dest),
		.flag_negative     (flag_negative),
		.flag_zero_out     (flag_zero_out)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("timeout: %0d results still outstanding", pending_results.size());
		$display("FAIL data_processing_execute");
		$finish;
	end

	function automatic word_t rotr(word_t v, logic [4:0] n);
		if (n == 5'd0)
			return v;
		return (v >> n) | (v << (6'd32 - n));
	endfunction

	function automatic word_t shift_rm(logic [1:0] kind, logic [7:0] amount, word_t v);
		word_t r;
		if (amount == 8'd0)
			return v;
		case (kind)
			SH_LSL: begin
				if (amount >= 8'd32) r = '0;
				else r = v << amount;
			end
			SH_LSR: begin
				if (amount >= 8'd32) r = '0;
				else r = v >> amount;
			end
			SH_ASR: begin
				if (amount >= 8'd32) r = {32{v[31]}};
				else r = $signed(v) >>> amount;
			end
			default: r = rotr(v, amount[4:0]);
		endcase
		return r;
	endfunction

	// Compute the result of one instruction and advance the model state.
	function automatic exec_result_t predict_execute(word_t w);
		exec_result_t res;
		word_t rn_val;
		word_t op2;
		word_t value;
		logic known;
		logic writes;
		rn_val = model_regs[w[19:16]];
		if (w[25])
			op2 = rotr({24'b0, w[7:0]}, {w[11:8], 1'b0});
		else if (w[4])
			op2 = shift_rm(w[6:5], model_regs[w[11:8]][7:0], model_regs[w[3:0]]);
		else
			op2 = shift_rm(w[6:5], {3'b0, w[11:7]}, model_regs[w[3:0]]);
		value = '0;
		known = 1'b1;
		writes = 1'b0;
		case (w[24:21])
			OP_AND: begin value = rn_val & op2; writes = 1'b1; end
			OP_EOR: begin value = rn_val ^ op2; writes = 1'b1; end
			OP_SUB: begin value = rn_val - op2; writes = 1'b1; end
			OP_RSB: begin value = op2 - rn_val; writes = 1'b1; end
			OP_ADD: begin value = rn_val + op2; writes = 1'b1; end
			OP_TST: value = rn_val & op2;
			OP_TEQ: value = rn_val ^ op2;
			OP_CMP: value = rn_val - op2;
			OP_ORR: begin value = rn_val | op2; writes = 1'b1; end
			OP_MOV: begin value = op2; writes = 1'b1; end
			default: known = 1'b0;
		endcase
		if (writes)
			model_regs[w[15:12]] = value;
		if (known && w[20]) begin
			model_neg = value[31];
			model_zero = (value == '0);
		end
		res.dest = w[15:12];
		res.value = value;
		res.wrote = writes;
		res.neg = model_neg;
		res.zero = model_zero;
		return res;
	endfunction

	function automatic word_t enc_imm(logic [3:0] op, logic s, reg_idx_t rn, reg_idx_t rd,
		logic [3:0] rot, logic [7:0] imm);
		logic [3:0] cond;
		cond = 4'($urandom);
		return {cond, 2'b00, 1'b1, op, s, rn, rd, rot, imm};
	endfunction

	function automatic word_t enc_const(logic [3:0] op, logic s, reg_idx_t rn, reg_idx_t rd,
		logic [4:0] sh, logic [1:0] kind, reg_idx_t rm);
		logic [3:0] cond;
		cond = 4'($urandom);
		return {cond, 2'b00, 1'b0, op, s, rn, rd, sh, kind, 1'b0, rm};
	endfunction

	function automatic word_t enc_rs(logic [3:0] op, logic s, reg_idx_t rn, reg_idx_t rd,
		reg_idx_t rs, logic [1:0] kind, reg_idx_t rm);
		logic [3:0] cond;
		cond = 4'($urandom);
		return {cond, 2'b00, 1'b0, op, s, rn, rd, rs, 1'b0, kind, 1'b1, rm};
	endfunction

	// Mostly well-formed words with random fields, some small moves to seed
	// short register shift amounts, and some raw noise.
	function automatic word_t rand_instruction();
		int pick;
		int form;
		logic [3:0] op;
		word_t w;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			op = UNLISTED_OPS[$urandom_range(0, 5)];
		else
			op = LISTED_OPS[$urandom_range(0, 9)];
		form = $urandom_range(0, 2);
		if (pick >= 88)
			return $urandom;
		if (pick >= 78)
			return enc_imm(OP_MOV, 1'($urandom), 4'($urandom), 4'($urandom), 4'd0,
				8'($urandom_range(0, 40)));
		case (form)
			0: w = enc_imm(op, 1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
				8'($urandom));
			1: w = enc_const(op, 1'($urandom), 4'($urandom), 4'($urandom), 5'($urandom),
				2'($urandom), 4'($urandom));
			default: w = enc_rs(op, 1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
				2'($urandom), 4'($urandom));
		endcase
		// Toggle the bits the block ignores now and then.
		if ($urandom_range(0, 3) == 0)
			w[27:26] = 2'($urandom);
		if (!w[25] && w[4] && $urandom_range(0, 3) == 0)
			w[7] = 1'b1;
		return w;
	endfunction

	task automatic note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	// Offer one transaction and hold it until accepted.
	task automatic send_instr(word_t w);
		int gap;
		gap = send_gaps ? $urandom_range(0, 8) : 0;
		repeat (gap) begin
			@(negedge clk);
			instruction_valid <= 1'b0;
			instruction <= $urandom;
		end
		@(negedge clk);
		instruction_valid <= 1'b1;
		instruction <= w;
		do @(posedge clk); while (!(instruction_valid && instruction_ready));
		pending_results.push_back(predict_execute(w));
		sent_count++;
	endtask

	initial begin : result_sink
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_cycles > 0) begin
				@(negedge clk);
				result_ready <= 1'b0;
				repeat (hold_cycles - 1) @(negedge clk);
				hold_cycles = 0;
			end
			stall = recv_gaps ? $urandom_range(0, 8) : 0;
			repeat (stall) begin
				@(negedge clk);
				result_ready <= 1'b0;
			end
			@(negedge clk);
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
		end
	end

	always @(posedge clk) begin : check_results
		exec_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result rd=%0d value=%h", dest_index,
					alu_value));
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (want.wrote)
					written_count++;
				if (dest_index !== want.dest || alu_value !== want.value
						|| wrote_dest !== want.wrote || flag_negative !== want.neg
						|| flag_zero_out !== want.zero)
					note_mismatch($sformatf(
						"exp rd=%0d val=%h wr=%b n=%b z=%b, got rd=%0d val=%h wr=%b n=%b z=%b",
						want.dest, want.value, want.wrote, want.neg, want.zero,
						dest_index, alu_value, wrote_dest, flag_negative, flag_zero_out));
			end
		end
	end

	task automatic test_directed();
		int i;
		// Immediate extremes: no rotate, rotate by 30, sign bit, zero
		send_instr(enc_imm(OP_MOV, 1'b1, 4'd0, 4'd1, 4'd0, 8'hFF));
		send_instr(enc_imm(OP_MOV, 1'b1, 4'd9, 4'd2, 4'hF, 8'hFF));
		send_instr(enc_imm(OP_MOV, 1'b1, 4'd0, 4'd3, 4'd1, 8'h02));
		send_instr(enc_imm(OP_MOV, 1'b1, 4'd0, 4'd4, 4'd0, 8'h00));
		send_instr(32'h0000_0000);
		// Every operation; a constant shift of zero for each shift kind
		send_instr(enc_const(OP_EOR, 1'b1, 4'd1, 4'd5, 5'd0, SH_LSR, 4'd3));
		send_instr(enc_const(OP_SUB, 1'b1, 4'd4, 4'd6, 5'd0, SH_ASR, 4'd1));
		send_instr(enc_const(OP_RSB, 1'b0, 4'd1, 4'd7, 5'd0, SH_ROR, 4'd2));
		send_instr(enc_const(OP_ADD, 1'b1, 4'd3, 4'd8, 5'd31, SH_LSL, 4'd1));
		send_instr(enc_const(OP_TST, 1'b1, 4'd1, 4'd9, 5'd31, SH_ASR, 4'd3));
		send_instr(enc_const(OP_TEQ, 1'b1, 4'd3, 4'd10, 5'd1, SH_LSR, 4'd3));
		send_instr(enc_const(OP_CMP, 1'b1, 4'd1, 4'd11, 5'd8, SH_ROR, 4'd1));
		send_instr(enc_imm(OP_ORR, 1'b0, 4'd1, 4'd12, 4'd4, 8'hA5));
		send_instr(enc_imm(OP_MOV, 1'b0, 4'd0, 4'd13, 4'd0, 8'd32));
		// Unlisted opcodes with S set change nothing
		for (i = 0; i < 6; i++)
			send_instr(enc_const(UNLISTED_OPS[i], 1'b1, 4'($urandom), 4'($urandom),
				5'($urandom), 2'($urandom), 4'($urandom)));
		// Register shifts by 32, by 252 and by zero
		send_instr(enc_rs(OP_MOV, 1'b1, 4'd0, 4'd14, 4'd13, SH_LSL, 4'd3));
		send_instr(enc_rs(OP_MOV, 1'b1, 4'd0, 4'd14, 4'd13, SH_LSR, 4'd3));
		send_instr(enc_rs(OP_MOV, 1'b1, 4'd0, 4'd14, 4'd2, SH_ASR, 4'd3));
		send_instr(enc_rs(OP_MOV, 1'b1, 4'd0, 4'd14, 4'd13, SH_ROR, 4'd5));
		send_instr(enc_rs(OP_ADD, 1'b1, 4'd4, 4'd14, 4'd4, SH_LSL, 4'd1));
		// Register 15 as Rd, Rn, Rm and Rs at once
		send_instr(enc_imm(OP_MOV, 1'b0, 4'd0, 4'd15, 4'd2, 8'h81));
		send_instr(enc_rs(OP_ADD, 1'b1, 4'd15, 4'd15, 4'd15, SH_ROR, 4'd15));
		send_instr(32'hFFFF_FFFF);
	endtask

	task automatic test_random_traffic(int count);
		repeat (count) send_instr(rand_instruction());
	endtask

	task automatic test_back_to_back(int count);
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		repeat (count) send_instr(rand_instruction());
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
	endtask

	// Stall the output long enough for the pipeline to fill and block input.
	task automatic test_backpressure(int rounds, int count);
		send_gaps = 1'b0;
		repeat (rounds) begin
			hold_cycles = 80;
			repeat (count) send_instr(rand_instruction());
		end
		send_gaps = 1'b1;
	endtask

	initial begin : main_seq
		int i;
		arst_n = 1'b0;
		instruction_valid = 1'b0;
		instruction = '0;
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		hold_cycles = 0;
		sent_count = 0;
		checked_count = 0;
		written_count = 0;
		mismatch_count = 0;
		for (i = 0; i < 16; i++)
			model_regs[i] = '0;
		model_neg = 1'b0;
		model_zero = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic(1100);
		test_back_to_back(300);
		test_backpressure(2, 60);

		@(negedge clk);
		instruction_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d instructions (directed, random, back-to-back, output stalls)",
			sent_count);
		$display("checked %0d results, %0d with Rd written, %0d mismatches",
			checked_count, written_count, mismatch_count);
		if (mismatch_count == 0)
			$display("PASS data_processing_execute");
		else
			$display("FAIL data_processing_execute");
		$finish;
	end

endmodule

[filelist.f]
sv/dpe_pkg.sv
sv/dpe_regfile.sv
sv/dpe_operand2.sv
sv/dpe_alu.sv
sv/data_processing_execute.sv
sv/dpe_checker.sv
tb/data_processing_execute_tb.sv
